@@ rtl/memory_pattern_test_engine_macros.svh @@
// Assertion macros used by the memory pattern test engine checker.
`ifndef MEMORY_PATTERN_TEST_ENGINE_MACROS_SVH
`define MEMORY_PATTERN_TEST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPTE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("memory pattern test engine assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MPTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("memory pattern test engine assertion failed");

`endif

@@ rtl/mpte_pkg.sv @@
// Types, codes and pattern function of the memory pattern test engine.
`timescale 1ns / 1ps

package mpte_pkg;

  // Input action codes.
  localparam logic [1:0] ACT_START      = 2'd0;
  localparam logic [1:0] ACT_WRITE_DONE = 2'd1;
  localparam logic [1:0] ACT_READ_DATA  = 2'd2;

  // Result command codes.
  localparam logic [1:0] CMD_IDLE   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_FINISH = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_START_ADDR = 1'b0;
  localparam logic CFG_END_ADDR   = 1'b1;

  localparam logic [2:0]  LAST_PATTERN = 3'd5;
  localparam logic [31:0] PAT_ODD_BITS  = 32'h5555_5555;
  localparam logic [31:0] PAT_EVEN_BITS = 32'hAAAA_AAAA;
  localparam logic [31:0] PAT_ZEROS     = 32'h0000_0000;
  localparam logic [31:0] PAT_ONES      = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    PHASE_IDLE,
    PHASE_WRITE,
    PHASE_READ
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  pattern;
    logic [29:0] cursor;
    logic        error_seen;
  } eng_state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] mem_address;
    logic [31:0] write_word;
    logic [2:0]  pattern_index;
    logic        mismatch;
    logic [31:0] fail_address;
    logic [31:0] fail_data;
    logic        all_passed;
  } result_t;

  // Expected data word for a pattern at a given word address.
  function automatic logic [31:0] pattern_value(input logic [2:0] pat,
                                                input logic [29:0] word);
    logic [31:0] byte_addr;
    byte_addr = {word, 2'b00};
    case (pat)
      3'd0:    pattern_value = PAT_ODD_BITS;
      3'd1:    pattern_value = PAT_EVEN_BITS;
      3'd2:    pattern_value = PAT_ZEROS;
      3'd3:    pattern_value = PAT_ONES;
      3'd4:    pattern_value = byte_addr;
      default: pattern_value = ~byte_addr;
    endcase
  endfunction

endpackage

@@ rtl/memory_pattern_test_engine.sv @@
// Top level of the memory pattern test engine.
`timescale 1ns / 1ps
// The engine drives a memory through six data patterns (alternating bits
// both ways, all zeros, all ones, the word's byte address and its inverse).
// For each pattern it writes every word of the range set by start_address
// and end_address (end exclusive), then reads the range back and compares.
// The input channel carries one action per transfer: start a run, the
// previous write was accepted, or read data returned. The result channel
// answers every input transfer with exactly one result transfer holding the
// next memory command (idle, write, read or finished), its address and write
// data, the pattern number, any mismatch with its address and data, and the
// pass flag on the finishing result.
// Configuration registers are written through the cfg_ channel, which is
// always ready; index 0 is start_address, index 1 is end_address. Write them
// only while no run step is in flight.
// An input transfer lands in an input register; the step logic then updates
// the engine state and loads the result register, so each result passes
// through the input register and the result register before it is offered.
// One item is taken per cycle while results are accepted. When the receiver
// stalls, the result register holds its transfer and the input register
// absorbs one more, after which in_tready drops.
// The synchronous reset clears both registers' valid flags, the engine state
// and the configuration registers.

module memory_pattern_test_engine import mpte_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // Input channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] read_data
  input  logic [1:0]   in_tuser,   // [1:0] action
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] mem_address, [63:32] write_word, [66:64] pattern_index,
  // [67] mismatch, [99:68] fail_address, [131:100] fail_data,
  // [132] all_passed, [135:133] zero
  output logic [135:0] out_tdata,
  output logic [1:0]   out_tuser,  // [1:0] command
  // Configuration write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  logic        item_valid;
  logic [1:0]  item_action;
  logic [31:0] item_read_data;
  logic        advance;

  logic [31:0] start_address_r;
  logic [31:0] end_address_r;

  eng_state_t  state_r;
  eng_state_t  state_nxt;
  result_t     step_res;

  logic        out_valid_r;
  result_t     out_res_r;

  // The step fires whenever an item waits and the result register is free
  // or is being emptied in this cycle.
  assign advance = item_valid && (!out_valid_r || out_tready);

  mpte_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_action    (in_tuser),
    .in_read_data (in_tdata),
    .advance      (advance),
    .valid        (item_valid),
    .action       (item_action),
    .read_data    (item_read_data)
  );

  mpte_step u_step (
    .st         (state_r),
    .action     (item_action),
    .read_data  (item_read_data),
    .first_word (start_address_r[31:2]),
    .stop_word  (end_address_r[31:2]),
    .st_nxt     (state_nxt),
    .res        (step_res)
  );

  // Configuration registers; every write transfer is taken at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_address_r <= '0;
      end_address_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_ADDR: start_address_r <= cfg_data;
        CFG_END_ADDR:   end_address_r   <= cfg_data;
        default:        start_address_r <= start_address_r;
      endcase
    end
  end

  // Engine state advances once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= PHASE_IDLE;
      state_r.pattern    <= '0;
      state_r.cursor     <= '0;
      state_r.error_seen <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.cmd;
  assign out_tdata  = {3'b000,
                       out_res_r.all_passed,
                       out_res_r.fail_data,
                       out_res_r.fail_address,
                       out_res_r.mismatch,
                       out_res_r.pattern_index,
                       out_res_r.write_word,
                       out_res_r.mem_address};

endmodule

@@ rtl/mpte_in_reg.sv @@
// Input register stage of the memory pattern test engine.
`timescale 1ns / 1ps

module mpte_in_reg import mpte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_read_data,
  input  logic        advance,
  output logic        valid,
  output logic [1:0]  action,
  output logic [31:0] read_data
);

  logic        valid_r;
  logic [1:0]  action_r;
  logic [31:0] read_data_r;

  // The stage can refill in the same cycle that it hands its item on.
  assign in_tready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      action_r    <= in_action;
      read_data_r <= in_read_data;
    end
  end

  assign valid     = valid_r;
  assign action    = action_r;
  assign read_data = read_data_r;

endmodule

@@ rtl/mpte_step.sv @@
// Next-state and result logic for one engine step.
`timescale 1ns / 1ps

module mpte_step import mpte_pkg::*; (
  input  eng_state_t  st,
  input  logic [1:0]  action,
  input  logic [31:0] read_data,
  input  logic [29:0] first_word,
  input  logic [29:0] stop_word,
  output eng_state_t  st_nxt,
  output result_t     res
);

  logic [29:0] cursor_inc;
  logic        inc_in_range;
  logic        first_in_range;
  logic        more_patterns;
  logic        write_ok;
  logic        read_ok;
  logic        data_bad;
  logic [1:0]  cmd;

  assign cursor_inc     = st.cursor + 30'd1;
  assign inc_in_range   = cursor_inc < stop_word;
  assign first_in_range = first_word < stop_word;
  assign more_patterns  = st.pattern < LAST_PATTERN;
  assign write_ok       = (action == ACT_WRITE_DONE) && (st.phase == PHASE_WRITE);
  assign read_ok        = (action == ACT_READ_DATA) && (st.phase == PHASE_READ);
  assign data_bad       = read_ok && (read_data != pattern_value(st.pattern, st.cursor));

  // Next state.
  always_comb begin
    st_nxt = st;
    case (action)
      ACT_START: begin
        st_nxt.pattern    = 3'd0;
        st_nxt.error_seen = 1'b0;
        st_nxt.cursor     = first_word;
        st_nxt.phase      = first_in_range ? PHASE_WRITE : PHASE_IDLE;
      end
      ACT_WRITE_DONE: begin
        if (write_ok) begin
          if (inc_in_range) begin
            st_nxt.cursor = cursor_inc;
          end else begin
            st_nxt.cursor = first_word;
            st_nxt.phase  = first_in_range ? PHASE_READ : PHASE_IDLE;
          end
        end
      end
      ACT_READ_DATA: begin
        if (read_ok) begin
          if (data_bad) begin
            st_nxt.error_seen = 1'b1;
          end
          if (inc_in_range) begin
            st_nxt.cursor = cursor_inc;
          end else if (more_patterns) begin
            st_nxt.pattern = st.pattern + 3'd1;
            st_nxt.cursor  = first_word;
            st_nxt.phase   = first_in_range ? PHASE_WRITE : PHASE_IDLE;
          end else begin
            st_nxt.cursor = cursor_inc;
            st_nxt.phase  = PHASE_IDLE;
          end
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

  // Command selection.
  always_comb begin
    cmd = CMD_IDLE;
    case (action)
      ACT_START: begin
        cmd = first_in_range ? CMD_WRITE : CMD_FINISH;
      end
      ACT_WRITE_DONE: begin
        if (write_ok) begin
          if (inc_in_range) begin
            cmd = CMD_WRITE;
          end else begin
            cmd = first_in_range ? CMD_READ : CMD_FINISH;
          end
        end
      end
      ACT_READ_DATA: begin
        if (read_ok) begin
          if (inc_in_range) begin
            cmd = CMD_READ;
          end else if (more_patterns && first_in_range) begin
            cmd = CMD_WRITE;
          end else begin
            cmd = CMD_FINISH;
          end
        end
      end
      default: begin
        cmd = CMD_IDLE;
      end
    endcase
  end

  // Result fields follow from the command and the updated state.
  always_comb begin
    res               = '0;
    res.cmd           = cmd;
    res.pattern_index = st_nxt.pattern;
    if (cmd == CMD_WRITE || cmd == CMD_READ) begin
      res.mem_address = {st_nxt.cursor, 2'b00};
    end
    if (cmd == CMD_WRITE) begin
      res.write_word = pattern_value(st_nxt.pattern, st_nxt.cursor);
    end
    if (data_bad) begin
      res.mismatch     = 1'b1;
      res.fail_address = {st.cursor, 2'b00};
      res.fail_data    = read_data;
    end
    res.all_passed = (cmd == CMD_FINISH) && !st_nxt.error_seen;
  end

endmodule

@@ rtl/mpte_checker.sv @@
// Port-level checker for the memory pattern test engine and its bind.
`timescale 1ns / 1ps
`include "memory_pattern_test_engine_macros.svh"

module mpte_checker import mpte_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata,
  input logic [1:0]   out_tuser
);

  // A stalled result transfer stays offered and unchanged.
  `MPTE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // The pass flag appears only on the finishing result.
  `MPTE_ASSERT_IMPL(a_pass_on_finish, clk, rst_n, out_tvalid && (out_tuser != CMD_FINISH), !out_tdata[132])

  // Failure fields are clear unless a mismatch is reported.
  `MPTE_ASSERT_IMPL(a_fail_fields_clear, clk, rst_n, out_tvalid && !out_tdata[67], out_tdata[131:68] == 64'd0)

  // The pattern number never runs past the last pattern.
  `MPTE_ASSERT_IMPL(a_pattern_range, clk, rst_n, out_tvalid, out_tdata[66:64] <= LAST_PATTERN)

endmodule

bind memory_pattern_test_engine mpte_checker u_mpte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
